// ----- design/cvsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cache victim scoring policy.
// No dependencies; every other file of the block imports this package.
package cvsp_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int DEF_NUM_SETS        = 2048;
    localparam int DEF_NUM_WAYS        = 16;
    localparam int DEF_PC_HIST_DEPTH   = 8;
    localparam int DEF_ADDR_HIST_DEPTH = 8;

    // Fixed field widths of the interface.
    localparam int WORD_W     = 64;
    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // A 64-byte cache block: byte address bits below this are dropped.
    localparam int BLOCK_SHIFT = 6;

    // Width of the signed scores and of one penalty product.
    localparam int SCORE_W = 48;
    localparam int PEN_W   = 16;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_NEAR_DIST       = 8'd2;
    localparam logic [CFG_W-1:0] RST_PC_PENALTY      = 8'd8;
    localparam logic [CFG_W-1:0] RST_SPATIAL_PENALTY = 8'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_DIST       = 2'd0,
        CFG_PC_PENALTY      = 2'd1,
        CFG_SPATIAL_PENALTY = 2'd2
    } cfg_index_t;

    // Operation codes of an input transaction.
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register set as seen by the scorer.
    typedef struct packed {
        logic [CFG_W-1:0] near_dist;
        logic [CFG_W-1:0] pc_penalty;
        logic [CFG_W-1:0] spatial_penalty;
    } cvsp_cfg_t;

    // Per-way record kept in the way memory.
    typedef struct packed {
        logic [WORD_W-1:0] ts;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] addr;
    } way_entry_t;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_MAP   = 9'b000000100,
        ST_ADDR  = 9'b000001000,
        ST_READ  = 9'b000010000,
        ST_UPD   = 9'b000100000,
        ST_QRY   = 9'b001000000,
        ST_WAIT  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

endpackage

// ----- design/cvsp_scorer.sv -----
`timescale 1ns / 1ps
// Three-stage scoring pipeline: history compares, score sums, victim select tree.
// Depends on cvsp_pkg for the way record, the configuration struct and widths.
module cvsp_scorer
    import cvsp_pkg::*;
#(
    parameter int NUM_WAYS        = DEF_NUM_WAYS,
    parameter int PC_HIST_DEPTH   = DEF_PC_HIST_DEPTH,
    parameter int ADDR_HIST_DEPTH = DEF_ADDR_HIST_DEPTH
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     go,
    input  way_entry_t [NUM_WAYS-1:0]                way_row,
    input  logic [PC_HIST_DEPTH-1:0][WORD_W-1:0]     pc_hist,
    input  logic [ADDR_HIST_DEPTH-1:0][WORD_W-1:0]   addr_hist,
    input  logic [WORD_W-1:0]                        counter,
    input  cvsp_cfg_t                                cfg,
    output logic                                     done,
    output logic [$clog2(NUM_WAYS)-1:0]              victim
);

    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int TREE_N  = 1 << WAY_W;
    localparam int PCC_W   = $clog2(PC_HIST_DEPTH + 1);
    localparam int ADC_W   = $clog2(ADDR_HIST_DEPTH + 1);
    localparam int BLK_W   = WORD_W - BLOCK_SHIFT;

    typedef struct packed {
        logic                      valid;
        logic signed [SCORE_W-1:0] score;
        logic [WORD_W-1:0]         ts;
        logic [WAY_W-1:0]          idx;
    } node_t;

    logic [NUM_WAYS-1:0][PC_HIST_DEPTH-1:0]   pc_match;
    logic [NUM_WAYS-1:0][ADDR_HIST_DEPTH-1:0] ad_match;

    logic [31:0]                 age_reg   [NUM_WAYS];
    logic [PCC_W-1:0]            pcc_reg   [NUM_WAYS];
    logic [ADC_W-1:0]            adc_reg   [NUM_WAYS];
    logic [WORD_W-1:0]           ts1_reg   [NUM_WAYS];
    logic signed [SCORE_W-1:0]   score_reg [NUM_WAYS];
    logic [WORD_W-1:0]           ts2_reg   [NUM_WAYS];
    logic                        v1_reg;
    logic                        v2_reg;
    logic                        done_reg;
    logic [WAY_W-1:0]            victim_reg;
    node_t                       nodes [TREE_N];

    // True when two byte addresses lie within the radius in block numbers.
    function automatic logic blocks_near(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [CFG_W-1:0]  radius
    );
        logic [BLK_W-1:0] ba;
        logic [BLK_W-1:0] bb;
        logic [BLK_W-1:0] d;
        ba = a[WORD_W-1:BLOCK_SHIFT];
        bb = b[WORD_W-1:BLOCK_SHIFT];
        d  = (ba >= bb) ? (ba - bb) : (bb - ba);
        return d <= BLK_W'(radius);
    endfunction

    // Lexicographic pick: higher score, then smaller timestamp, else the left node.
    function automatic node_t pick(input node_t l, input node_t r);
        if (!r.valid)
            return l;
        if (!l.valid)
            return r;
        if ((r.score > l.score) || ((r.score == l.score) && (r.ts < l.ts)))
            return r;
        return l;
    endfunction

    // Compare every way against every history entry of the set.
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            for (int i = 0; i < PC_HIST_DEPTH; i++)
            begin
                pc_match[w][i] = (pc_hist[i] == way_row[w].pc);
            end
            for (int j = 0; j < ADDR_HIST_DEPTH; j++)
            begin
                ad_match[w][j] = blocks_near(way_row[w].addr, addr_hist[j],
                                             cfg.near_dist);
            end
        end
    end

    // Stage one: match counts and ages.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                age_reg[w] <= 32'(counter - way_row[w].ts);
                pcc_reg[w] <= PCC_W'($countones(pc_match[w]));
                adc_reg[w] <= ADC_W'($countones(ad_match[w]));
                ts1_reg[w] <= way_row[w].ts;
            end
        end
    end

    // Stage two: signed score of each way.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                score_reg[w] <= SCORE_W'($signed(age_reg[w]))
                    - $signed(SCORE_W'(PEN_W'(PEN_W'(pcc_reg[w]) * PEN_W'(cfg.pc_penalty))))
                    - $signed(SCORE_W'(PEN_W'(PEN_W'(adc_reg[w])
                                              * PEN_W'(cfg.spatial_penalty))));
                ts2_reg[w] <= ts1_reg[w];
            end
        end
    end

    // Selection tree over the scored ways, lower index preferred on a full tie.
    always_comb
    begin
        for (int i = 0; i < TREE_N; i++)
        begin
            if (i < NUM_WAYS)
            begin
                nodes[i].valid = 1'b1;
                nodes[i].score = score_reg[i];
                nodes[i].ts    = ts2_reg[i];
                nodes[i].idx   = WAY_W'(i);
            end
            else
            begin
                nodes[i] = '0;
            end
        end
        for (int l = 0; l < WAY_W; l++)
        begin
            for (int i = 0; i < (TREE_N >> (l + 1)); i++)
            begin
                nodes[i] = pick(nodes[2 * i], nodes[2 * i + 1]);
            end
        end
    end

    // Stage three: registered victim.
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            victim_reg <= nodes[0].idx;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= go;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign done   = done_reg;
    assign victim = victim_reg;

endmodule

// ----- design/cache_victim_scoring_policy.sv -----
`timescale 1ns / 1ps
// Top level of the cache victim scoring policy: sequencer, set-row memories,
// configuration registers and output register. Depends on cvsp_pkg and cvsp_scorer.
//
// One transaction is worked on at a time. The set index is first reduced modulo
// NUM_SETS in the states ST_MAP and ST_ADDR, then one row of the way memory and one
// row of the history memory are read in ST_READ. An update writes both rows back
// in the next cycle if its way index is below NUM_WAYS, and the block then returns
// to idle, ready to accept the next transaction. A query runs the row through the
// three-stage scorer and loads the output register once that register is no longer
// held by a stalled result. After reset a clearing pass writes zero to every set
// row, during which in_stall stays high; configuration writes are taken at any time.
module cache_victim_scoring_policy
    import cvsp_pkg::*;
#(
    parameter int NUM_SETS        = DEF_NUM_SETS,
    parameter int NUM_WAYS        = DEF_NUM_WAYS,
    parameter int PC_HIST_DEPTH   = DEF_PC_HIST_DEPTH,
    parameter int ADDR_HIST_DEPTH = DEF_ADDR_HIST_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [SET_IN_W-1:0]   set_index,
    input  logic [WAY_IN_W-1:0]   way_index,
    input  logic [WORD_W-1:0]     pc_value,
    input  logic [WORD_W-1:0]     phys_addr,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WAY_IN_W-1:0]   victim_way,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int PCP_W    = (PC_HIST_DEPTH > 1) ? $clog2(PC_HIST_DEPTH) : 1;
    localparam int ADP_W    = (ADDR_HIST_DEPTH > 1) ? $clog2(ADDR_HIST_DEPTH) : 1;
    localparam int PCH_W    = PC_HIST_DEPTH * WORD_W;
    localparam int ADH_W    = ADDR_HIST_DEPTH * WORD_W;
    localparam int HIST_W   = PCH_W + ADH_W + PCP_W + ADP_W;
    // Modulo by reciprocal: quotient estimate is exact or one low.
    localparam int RECIP_SH = 22;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SET_IN_W + RECIP_W;
    localparam int Q_W      = SET_IN_W + 1;
    localparam int REM_W    = 29;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'(1) << RECIP_SH) / NUM_SETS);

    // Sequencer and control.
    state_t                   state_reg, state_next;
    logic [SET_W-1:0]         clr_cnt_reg;
    logic [WORD_W-1:0]        counter_reg;
    cvsp_cfg_t                cfg_reg;
    logic                     out_valid_reg;
    logic [WAY_IN_W-1:0]      out_way_reg;

    // Captured transaction.
    logic                     op_reg;
    logic [SET_IN_W-1:0]      raw_set_reg;
    logic [WAY_IN_W-1:0]      way_reg;
    logic [WORD_W-1:0]        pc_reg;
    logic [WORD_W-1:0]        addr_reg;
    logic [Q_W-1:0]           q_reg;
    logic [SET_W-1:0]         set_reg;

    // Set reduction.
    logic [PROD_W-1:0]        prod;
    logic [REM_W-1:0]         rem;
    logic [REM_W-1:0]         rem_fix;

    // Memories and their ports.
    way_entry_t [NUM_WAYS-1:0] way_mem [NUM_SETS];
    logic [HIST_W-1:0]         hist_mem [NUM_SETS];
    way_entry_t [NUM_WAYS-1:0] way_rd_reg;
    logic [HIST_W-1:0]         hist_rd_reg;
    way_entry_t [NUM_WAYS-1:0] way_mod;
    logic [HIST_W-1:0]         hist_mod;
    logic                      mem_we;
    logic [SET_W-1:0]          mem_wa;
    logic                      rd_en;
    logic                      upd_ok;

    // Unpacked history row.
    logic [PC_HIST_DEPTH-1:0][WORD_W-1:0]   pc_hist;
    logic [ADDR_HIST_DEPTH-1:0][WORD_W-1:0] addr_hist;
    logic [PC_HIST_DEPTH-1:0][WORD_W-1:0]   pc_hist_mod;
    logic [ADDR_HIST_DEPTH-1:0][WORD_W-1:0] addr_hist_mod;
    logic [PCP_W-1:0]                       pc_ptr;
    logic [ADP_W-1:0]                       ad_ptr;
    logic [PCP_W-1:0]                       pc_ptr_next;
    logic [ADP_W-1:0]                       ad_ptr_next;

    // Scorer handshake.
    logic                     score_go;
    logic                     score_done;
    logic [WAY_W-1:0]         score_victim;
    logic                     out_free;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign victim_way = out_way_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Set index modulo NUM_SETS.
    assign prod    = PROD_W'(raw_set_reg) * PROD_W'(RECIP);
    assign rem     = REM_W'(raw_set_reg) - REM_W'(q_reg) * REM_W'(NUM_SETS);
    assign rem_fix = (rem >= REM_W'(NUM_SETS)) ? (rem - REM_W'(NUM_SETS)) : rem;

    // History row fields.
    assign pc_hist   = hist_rd_reg[PCH_W-1:0];
    assign addr_hist = hist_rd_reg[PCH_W +: ADH_W];
    assign pc_ptr    = hist_rd_reg[PCH_W + ADH_W +: PCP_W];
    assign ad_ptr    = hist_rd_reg[PCH_W + ADH_W + PCP_W +: ADP_W];

    assign upd_ok = (32'(way_reg) < NUM_WAYS);

    // Modified rows for an update: record the way and push both histories.
    always_comb
    begin
        way_mod       = way_rd_reg;
        pc_hist_mod   = pc_hist;
        addr_hist_mod = addr_hist;
        way_mod[WAY_W'(way_reg)].ts   = counter_reg + WORD_W'(1);
        way_mod[WAY_W'(way_reg)].pc   = pc_reg;
        way_mod[WAY_W'(way_reg)].addr = addr_reg;
        pc_hist_mod[pc_ptr]   = pc_reg;
        addr_hist_mod[ad_ptr] = addr_reg;
        pc_ptr_next = (pc_ptr == PCP_W'(PC_HIST_DEPTH - 1)) ? '0 : pc_ptr + PCP_W'(1);
        ad_ptr_next = (ad_ptr == ADP_W'(ADDR_HIST_DEPTH - 1)) ? '0 : ad_ptr + ADP_W'(1);
        hist_mod = {ad_ptr_next, pc_ptr_next, addr_hist_mod, pc_hist_mod};
    end

    // Memory port control: clearing pass, update write-back and row read; scorer start.
    assign mem_we   = (state_reg == ST_CLEAR) || ((state_reg == ST_UPD) && upd_ok);
    assign mem_wa   = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign rd_en    = (state_reg == ST_READ);
    assign score_go = (state_reg == ST_QRY);

    // Way memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            way_mem[mem_wa] <= (state_reg == ST_CLEAR) ? '0 : way_mod;
        end
        if (rd_en)
        begin
            way_rd_reg <= way_mem[set_reg];
        end
    end

    // History memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_wa] <= (state_reg == ST_CLEAR) ? '0 : hist_mod;
        end
        if (rd_en)
        begin
            hist_rd_reg <= hist_mem[set_reg];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MAP;
            end
            ST_MAP:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = (op_reg == OP_UPDATE) ? ST_UPD : ST_QRY;
            ST_UPD:  state_next = ST_IDLE;
            ST_QRY:  state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (score_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg.near_dist       <= RST_NEAR_DIST;
            cfg_reg.pc_penalty      <= RST_PC_PENALTY;
            cfg_reg.spatial_penalty <= RST_SPATIAL_PENALTY;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            if ((state_reg == ST_UPD) && upd_ok)
                counter_reg <= counter_reg + WORD_W'(1);
            // Output register: load a finished query, drop a taken transaction.
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            // Configuration writes; unknown indexes are ignored.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_NEAR_DIST:       cfg_reg.near_dist       <= cfg_data;
                    CFG_PC_PENALTY:      cfg_reg.pc_penalty      <= cfg_data;
                    CFG_SPATIAL_PENALTY: cfg_reg.spatial_penalty <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // Transaction payload, set reduction and output way.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            op_reg      <= opcode;
            raw_set_reg <= set_index;
            way_reg     <= way_index;
            pc_reg      <= pc_value;
            addr_reg    <= phys_addr;
        end
        if (state_reg == ST_MAP)
            q_reg <= prod[RECIP_SH +: Q_W];
        if (state_reg == ST_ADDR)
            set_reg <= rem_fix[SET_W-1:0];
        if ((state_reg == ST_OUT) && out_free)
            out_way_reg <= WAY_IN_W'(score_victim);
    end

    cvsp_scorer #(
        .NUM_WAYS        (NUM_WAYS),
        .PC_HIST_DEPTH   (PC_HIST_DEPTH),
        .ADDR_HIST_DEPTH (ADDR_HIST_DEPTH)
    ) u_scorer (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (score_go),
        .way_row   (way_rd_reg),
        .pc_hist   (pc_hist),
        .addr_hist (addr_hist),
        .counter   (counter_reg),
        .cfg       (cfg_reg),
        .done      (score_done),
        .victim    (score_victim)
    );

endmodule
